[hw/rtl/pidc_pkg.sv]
// Shared constants and helper functions for the personal ID code checker.
// No dependencies; used by the request interface, the top level and the testbench.

package pidc_pkg;

   localparam int CharW  = 8;
   localparam int DigitW = 4;
   localparam int PosW   = 4;
   localparam int FieldW = 7;

   localparam logic [PosW-1:0] CodeLen  = PosW'(13);
   localparam logic [PosW-1:0] CheckIdx = PosW'(12);
   localparam logic [PosW-1:0] LeadIdx  = PosW'(0);
   localparam logic [PosW-1:0] YearEnd  = PosW'(2);
   localparam logic [PosW-1:0] MonthEnd = PosW'(4);
   localparam logic [PosW-1:0] DayEnd   = PosW'(6);
   localparam logic [PosW-1:0] CntyEnd  = PosW'(8);

   localparam logic [CharW-1:0] AsciiZero = 8'h30;
   localparam logic [CharW-1:0] AsciiNine = 8'h39;

   localparam logic [FieldW-1:0] CountyMax  = FieldW'(48);
   localparam logic [FieldW-1:0] CountyBucA = FieldW'(51);
   localparam logic [FieldW-1:0] CountyBucB = FieldW'(52);
   localparam logic [FieldW-1:0] CountyAlt  = FieldW'(70);

   typedef struct packed {
      logic [PosW-1:0]   pos;
      logic [DigitW-1:0] rem;
      logic [DigitW-1:0] lead;
      logic [FieldW-1:0] year;
      logic [FieldW-1:0] month;
      logic [FieldW-1:0] day;
      logic [FieldW-1:0] county;
      logic              bad;
   } code_state_type;

   // check weights 2 7 9 1 4 6 3 5 8 2 7 9 for digits 0..11
   function automatic logic [DigitW-1:0] digit_weight(input logic [PosW-1:0] idx);
      logic [DigitW-1:0] w;
      case (idx)
         4'd0:    w = 4'd2;
         4'd1:    w = 4'd7;
         4'd2:    w = 4'd9;
         4'd3:    w = 4'd1;
         4'd4:    w = 4'd4;
         4'd5:    w = 4'd6;
         4'd6:    w = 4'd3;
         4'd7:    w = 4'd5;
         4'd8:    w = 4'd8;
         4'd9:    w = 4'd2;
         4'd10:   w = 4'd7;
         4'd11:   w = 4'd9;
         default: w = 4'd0;
      endcase
      return w;
   endfunction

   // v mod 11 for v <= 91: quotient by reciprocal 187/2048, then subtract
   function automatic logic [DigitW-1:0] mod11(input logic [FieldW-1:0] v);
      logic [14:0]       p;
      logic [3:0]        q;
      logic [FieldW-1:0] r;
      p = 15'(v) * 15'd187;
      q = p[14:11];
      r = v - FieldW'({3'b000, q} * 7'd11);
      return r[DigitW-1:0];
   endfunction

   // shift one decimal digit into a two-digit field
   function automatic logic [FieldW-1:0] push_digit(input logic [FieldW-1:0] f,
                                                    input logic [DigitW-1:0] d);
      logic [10:0] t;
      t = ({4'b0000, f} * 11'd10) + {7'b0000000, d};
      return t[FieldW-1:0];
   endfunction

endpackage

[hw/rtl/pidc_req_if.sv]
// Request channel of the personal ID code checker: one character per beat.
// Depends on pidc_pkg for the character width.

interface pidc_req_if;
   logic                      valid;
   logic                      ready;
   logic [pidc_pkg::CharW-1:0] char_code;
   logic                      last;

   modport source(output valid, char_code, last, input ready);
   modport sink(input valid, char_code, last, output ready);
endinterface

[hw/rtl/pidc_rsp_if.sv]
// Response channel of the personal ID code checker: one verdict per beat.
// No package dependency.

interface pidc_rsp_if;
   logic valid;
   logic ready;
   logic valid_res;

   modport source(output valid, valid_res, input ready);
   modport sink(input valid, valid_res, output ready);
endinterface

[hw/rtl/personal_id_code_checker.sv]
// Personal ID code checker: streams a 13-digit identity code and reports validity.
// Depends on pidc_pkg, pidc_req_if and pidc_rsp_if.
//
// Usage:
//   req_ch carries one ASCII character per beat; last marks the final character.
//   rsp_ch carries one beat per code, valid_res = 1 when the code passes the
//   length, all-digit, lead digit, calendar date, county and check digit tests.
//   Characters before last produce no response beat.
// Pipeline: the last beat waits in the input register until the result
//   register is free; the verdict is then registered and sits in the result
//   register until it is taken.
// Throughput: one character per cycle unless a last beat is held, set by the
//   combinational mod-11 accumulator and digit update between the two registers.
// Stall: while a verdict waits on rsp_ch, characters keep flowing; only a
//   second last beat holds in the input register, and req_ch.ready drops
//   until the waiting verdict is taken.
// Reset (synchronous, active high): empties both registers and clears the
//   position, accumulator and digit fields; the next beat starts a new code.

module personal_id_code_checker (
   input logic      clock,
   input logic      reset,
   pidc_req_if.sink   req_ch,
   pidc_rsp_if.source rsp_ch
);

   logic                       s1_valid_ff, s1_valid_in;
   logic [pidc_pkg::CharW-1:0] s1_char_ff;
   logic                       s1_last_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_res_ff, rsp_res_in;

   pidc_pkg::code_state_type state_ff, state_in, step;

   logic                        req_take;
   logic                        out_free;
   logic                        s1_adv;
   logic                        is_digit;
   logic [pidc_pkg::DigitW-1:0] dig;
   logic [pidc_pkg::DigitW-1:0] need;
   logic [pidc_pkg::FieldW-1:0] wsum;
   logic                        leap;
   logic                        date_ok;
   logic                        county_ok;
   logic                        code_ok;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_adv       = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign req_take     = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.valid_res = rsp_res_ff;

   // per-character update
   always_comb begin
      is_digit = (s1_char_ff >= pidc_pkg::AsciiZero) && (s1_char_ff <= pidc_pkg::AsciiNine);
      dig      = is_digit ? pidc_pkg::DigitW'(s1_char_ff - pidc_pkg::AsciiZero) : '0;
      need     = (state_ff.rem == 4'd10) ? 4'd1 : state_ff.rem;
      wsum     = {3'b000, state_ff.rem}
               + pidc_pkg::FieldW'({3'b000, dig} * {3'b000, pidc_pkg::digit_weight(state_ff.pos)});

      step = state_ff;
      if (!is_digit) begin
         step.bad = 1'b1;
      end
      if (state_ff.pos >= pidc_pkg::CodeLen) begin
         step.bad = 1'b1;
         step.pos = pidc_pkg::CodeLen;
      end else begin
         if (state_ff.pos < pidc_pkg::CheckIdx) begin
            step.rem = pidc_pkg::mod11(wsum);
         end
         if (state_ff.pos == pidc_pkg::LeadIdx) begin
            step.lead = dig;
            if (dig < 4'd1 || dig > 4'd8) begin
               step.bad = 1'b1;
            end
         end else if (state_ff.pos <= pidc_pkg::YearEnd) begin
            step.year = pidc_pkg::push_digit(state_ff.year, dig);
         end else if (state_ff.pos <= pidc_pkg::MonthEnd) begin
            step.month = pidc_pkg::push_digit(state_ff.month, dig);
         end else if (state_ff.pos <= pidc_pkg::DayEnd) begin
            step.day = pidc_pkg::push_digit(state_ff.day, dig);
         end else if (state_ff.pos <= pidc_pkg::CntyEnd) begin
            step.county = pidc_pkg::push_digit(state_ff.county, dig);
         end else if (state_ff.pos == pidc_pkg::CheckIdx) begin
            if (dig != need) begin
               step.bad = 1'b1;
            end
         end
         step.pos = state_ff.pos + 4'd1;
      end
   end

   // verdict on the updated fields; the century is 1800, 1900 or 2000 (all
   // divisible by 4), so only year 00 needs the century to decide leap
   always_comb begin
      leap = (step.year[1:0] == 2'b00)
          && ((step.year != '0) || !(step.lead >= 4'd1 && step.lead <= 4'd4));

      date_ok = 1'b1;
      if (step.month < 7'd1 || step.month > 7'd12) begin
         date_ok = 1'b0;
      end
      if (step.day < 7'd1 || step.day > 7'd31) begin
         date_ok = 1'b0;
      end
      case (step.month)
         7'd2: begin
            if (step.day > (leap ? 7'd29 : 7'd28)) begin
               date_ok = 1'b0;
            end
         end
         7'd4, 7'd6, 7'd9, 7'd11: begin
            if (step.day > 7'd30) begin
               date_ok = 1'b0;
            end
         end
         default: ;
      endcase

      county_ok = ((step.county >= 7'd1) && (step.county <= pidc_pkg::CountyMax))
               || (step.county == pidc_pkg::CountyBucA)
               || (step.county == pidc_pkg::CountyBucB)
               || (step.county == pidc_pkg::CountyAlt);

      code_ok = !step.bad && (step.pos == pidc_pkg::CodeLen) && date_ok && county_ok;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      state_in = state_ff;
      if (s1_adv) begin
         state_in = s1_last_ff ? '0 : step;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (s1_adv && s1_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = code_ok;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_char_ff <= req_ch.char_code;
         s1_last_ff <= req_ch.last;
      end
      rsp_res_ff <= rsp_res_in;
   end

   a_rsp_from_last : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_last_ff))
      else $error("response raised without a last beat in the input register");

   a_clear_after_last : assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_last_ff) |=> (state_ff == '0))
      else $error("code state not cleared after last beat");

   a_pos_bound : assert property (@(posedge clock) disable iff (reset)
      state_ff.pos <= pidc_pkg::CodeLen)
      else $error("position beyond code length");

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_ch.ready))
      else $error("input stalled without a blocked verdict");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Testbench for personal_id_code_checker: streams identity codes one character per beat
// and checks each verdict against a predictor or a pinned value. Depends on pidc_pkg, pidc_req_if,
// pidc_rsp_if and the checker RTL.

module tb;
   import pidc_pkg::*;

   localparam int IdlePct      = 9;
   localparam int WatchLimit   = 2000;
   localparam int RandomChars  = 1100;
   localparam int LongHold     = 300;
   localparam int DrainCycles  = 8;
   localparam int Predicted    = -1;
   localparam logic [47:0] WeightDigits = 48'h279146358279;

   typedef struct {
      string text;
      int    pinned;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pidc_req_if req_ch();
   pidc_rsp_if rsp_ch();

   personal_id_code_checker DUT (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   code_state_type     code_st = '0;
   bit                 pending_verdicts[$];
   int                 pinned_verdicts[$];
   logic [CharW-1:0]   code_chars[$];
   int                 mismatch_count = 0;
   int                 verdict_no = 0;
   int                 chars_sent = 0;
   int                 stuck_cycles = 0;
   int                 hold_left = 0;
   bit                 hold_rsp_req = 1'b0;
   bit                 calm = 1'b0;
   int                 pin_now;
   bit                 want_now;

   // 'c' stands for the correct check digit, 'w' for a wrong one
   dir_row_type dir_rows[24] = '{
      '{"1", 0},
      '{"180010122114", 0},
      '{"180010122114c", Predicted},
      '{"1800101221111", Predicted},
      '{"1800101221110", 0},
      '{"180010122114w", 0},
      '{"180010122114c7", 0},
      '{"080010122114c", 0},
      '{"980010122114c", 0},
      '{"1/0010122114c", 0},
      '{"18001:122114c", 0},
      '{"800022970999c", Predicted},
      '{"100022952000c", Predicted},
      '{"500022951001c", Predicted},
      '{"396022948123c", Predicted},
      '{"400022901000c", Predicted},
      '{"219043101123c", Predicted},
      '{"612123140555c", Predicted},
      '{"213130101000c", Predicted},
      '{"213000101000c", Predicted},
      '{"213010100000c", Predicted},
      '{"213010149000c", Predicted},
      '{"213010053000c", Predicted},
      '{"799123199999c", Predicted}
   };

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int weight_of(input int idx);
      return int'(WeightDigits[47 - 4 * idx -: 4]);
   endfunction

   // check digit over the first twelve characters held in code_chars
   function automatic logic [CharW-1:0] check_char();
      int sum;
      int d;
      sum = 0;
      for (int i = 0; i < 12; i++) begin
         d = (code_chars[i] >= AsciiZero && code_chars[i] <= AsciiNine) ?
             int'(code_chars[i] - AsciiZero) : 0;
         sum += d * weight_of(i);
      end
      sum = sum % 11;
      if (sum == 10) sum = 1;
      return AsciiZero + CharW'(sum);
   endfunction

   function automatic void push_digits(input int v, input int n);
      int div;
      div = 1;
      repeat (n - 1) div *= 10;
      repeat (n) begin
         code_chars.push_back(AsciiZero + CharW'((v / div) % 10));
         div /= 10;
      end
   endfunction

   // advance the predicted checker state by one character; verdict counts only on last
   function automatic bit absorb_char(input logic [CharW-1:0] ch, input logic lst);
      int dig;
      int idx;
      int need;
      int full_year;
      int day_max;
      bit leap;
      bit date_good;
      bit county_good;
      bit verdict;
      dig = 0;
      idx = int'(code_st.pos);
      verdict = 1'b0;
      if (ch >= AsciiZero && ch <= AsciiNine) dig = int'(ch - AsciiZero);
      else code_st.bad = 1'b1;
      if (idx >= int'(CodeLen)) begin
         code_st.bad = 1'b1;
         code_st.pos = CodeLen;
      end else begin
         if (idx < int'(CheckIdx))
            code_st.rem = DigitW'((int'(code_st.rem) + dig * weight_of(idx)) % 11);
         if (idx == int'(LeadIdx)) begin
            code_st.lead = DigitW'(dig);
            if (dig < 1 || dig > 8) code_st.bad = 1'b1;
         end else if (idx <= int'(YearEnd)) begin
            code_st.year = FieldW'(int'(code_st.year) * 10 + dig);
         end else if (idx <= int'(MonthEnd)) begin
            code_st.month = FieldW'(int'(code_st.month) * 10 + dig);
         end else if (idx <= int'(DayEnd)) begin
            code_st.day = FieldW'(int'(code_st.day) * 10 + dig);
         end else if (idx <= int'(CntyEnd)) begin
            code_st.county = FieldW'(int'(code_st.county) * 10 + dig);
         end else if (idx == int'(CheckIdx)) begin
            need = (code_st.rem == 4'd10) ? 1 : int'(code_st.rem);
            if (dig != need) code_st.bad = 1'b1;
         end
         code_st.pos = PosW'(idx + 1);
      end
      if (lst) begin
         full_year = int'(code_st.year);
         case (code_st.lead)
            4'd1, 4'd2: full_year += 1900;
            4'd3, 4'd4: full_year += 1800;
            4'd5, 4'd6: full_year += 2000;
            default: ;
         endcase
         leap = (full_year % 400 == 0) || (full_year % 4 == 0 && full_year % 100 != 0);
         day_max = 31;
         if (code_st.month == 7'd2) day_max = leap ? 29 : 28;
         else if (code_st.month inside {7'd4, 7'd6, 7'd9, 7'd11}) day_max = 30;
         date_good = code_st.month >= 7'd1 && code_st.month <= 7'd12 &&
                     code_st.day >= 7'd1 && int'(code_st.day) <= day_max;
         county_good = (code_st.county >= 7'd1 && code_st.county <= CountyMax) ||
                       code_st.county == CountyBucA || code_st.county == CountyBucB ||
                       code_st.county == CountyAlt;
         verdict = !code_st.bad && code_st.pos == CodeLen && date_good && county_good;
         code_st = '0;
      end
      return verdict;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic send_beat(input logic [CharW-1:0] ch, input logic lst);
      while (!calm && $urandom_range(0, 99) < IdlePct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.char_code <= ch;
      req_ch.last      <= lst;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic send_code(input int pinned);
      pinned_verdicts.push_back(pinned);
      foreach (code_chars[i]) send_beat(code_chars[i], i == code_chars.size() - 1);
      chars_sent += code_chars.size();
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
   endtask

   task automatic build_random_code();
      int lead;
      int yr;
      int mon;
      int dd;
      int cty;
      int pick;
      code_chars.delete();
      // noise: random length, half digits and half arbitrary bytes
      if ($urandom_range(0, 99) < 20) begin
         repeat ($urandom_range(1, 16))
            code_chars.push_back($urandom_range(0, 1) ?
                                 AsciiZero + CharW'($urandom_range(0, 9)) :
                                 CharW'($urandom_range(0, 255)));
         return;
      end
      lead = $urandom_range(1, 8);
      yr   = $urandom_range(0, 99);
      mon  = $urandom_range(1, 12);
      dd   = $urandom_range(1, 31);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         mon = 2;
         dd  = 29;
         yr  = 4 * $urandom_range(0, 24);
      end else if (pick == 1) begin
         mon = $urandom_range(0, 19);
         dd  = $urandom_range(0, 39);
      end else if (pick < 5) begin
         dd = $urandom_range(28, 31);
      end
      pick = $urandom_range(0, 5);
      if (pick < 3) cty = $urandom_range(1, 48);
      else if (pick == 3) begin
         case ($urandom_range(0, 2))
            0: cty = int'(CountyBucA);
            1: cty = int'(CountyBucB);
            default: cty = int'(CountyAlt);
         endcase
      end else cty = $urandom_range(0, 99);
      push_digits(lead, 1);
      push_digits(yr, 2);
      push_digits(mon, 2);
      push_digits(dd, 2);
      push_digits(cty, 2);
      push_digits($urandom_range(0, 999), 3);
      code_chars.push_back($urandom_range(0, 9) == 0 ?
                           AsciiZero + CharW'($urandom_range(0, 9)) : check_char());
      // break a few well-formed codes: corrupt, cut short or extend
      case ($urandom_range(0, 19))
         0: code_chars[$urandom_range(0, 12)] = CharW'($urandom_range(0, 255));
         1: repeat ($urandom_range(1, 12)) void'(code_chars.pop_back());
         2: repeat ($urandom_range(1, 3))
               code_chars.push_back(AsciiZero + CharW'($urandom_range(0, 9)));
         default: ;
      endcase
   endtask

   // result side pacing; a long hold is counted down here
   always @(negedge clock) begin
      if (hold_rsp_req) begin
         hold_rsp_req = 1'b0;
         hold_left = LongHold;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IdlePct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            verdict_no++;
            if (pending_verdicts.size() == 0) begin
               report_mismatch($sformatf("verdict %0d = %0b with none expected",
                                         verdict_no, rsp_ch.valid_res));
            end else begin
               want_now = pending_verdicts.pop_front();
               if (rsp_ch.valid_res !== want_now)
                  report_mismatch($sformatf("verdict %0d: got %0b, want %0b",
                                            verdict_no, rsp_ch.valid_res, want_now));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.last) begin
               pin_now = pinned_verdicts.pop_front();
               want_now = absorb_char(req_ch.char_code, 1'b1);
               pending_verdicts.push_back(pin_now == Predicted ? want_now : bit'(pin_now));
            end else begin
               void'(absorb_char(req_ch.char_code, 1'b0));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         stuck_cycles = 0;
      else
         stuck_cycles++;
      if (stuck_cycles >= WatchLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int code_no;
      req_ch.valid     = 1'b0;
      req_ch.char_code = '0;
      req_ch.last      = 1'b0;
      rsp_ch.ready     = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[r]) begin
         code_chars.delete();
         for (int i = 0; i < dir_rows[r].text.len(); i++) begin
            if (dir_rows[r].text[i] == "c")
               code_chars.push_back(check_char());
            else if (dir_rows[r].text[i] == "w")
               code_chars.push_back(AsciiZero +
                                    CharW'((int'(check_char() - AsciiZero) + 1) % 10));
            else
               code_chars.push_back(dir_rows[r].text[i]);
         end
         send_code(dir_rows[r].pinned);
      end

      code_no = 0;
      chars_sent = 0;
      while (chars_sent < RandomChars) begin
         // stall the result side while codes keep coming, later drain fully
         if (code_no == 20) hold_rsp_req = 1'b1;
         if (code_no == 50) wait_drained();
         calm = (code_no >= 70 && code_no < 85);
         build_random_code();
         send_code(Predicted);
         code_no++;
      end
      calm = 1'b0;
      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

[files.f]
hw/rtl/pidc_pkg.sv
hw/rtl/pidc_req_if.sv
hw/rtl/pidc_rsp_if.sv
hw/rtl/personal_id_code_checker.sv
test/tb.sv
